// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker file of this project.
// Depends on nothing; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion, clocked on the rising edge and off during reset.
`define ASSERT_DIS(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: assertion lbl failed");

// Same-cycle implication built on the macro above.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  `ASSERT_DIS(lbl, clk, rst_n, (ante) |-> (cons))

// Next-cycle implication built on the first macro.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  `ASSERT_DIS(lbl, clk, rst_n, (ante) |=> (cons))

`endif

// ===== sv/itoa_pkg.sv =====
// Package of the integer to ASCII converter: widths, characters, states.
// Depends on nothing.
package itoa_pkg;

  localparam int unsigned NUM_W   = 64;
  localparam int unsigned DIGITS  = 20;
  localparam int unsigned BCD_W   = DIGITS * 4;
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned COUNT_W = 5;
  localparam int unsigned BIT_W   = 6;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_A     = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

  // Conversion modes carried in the input tuser bit.
  localparam logic MODE_DEC = 1'b0;
  localparam logic MODE_HEX = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_STRIP,
    ST_EMIT
  } state_e;

  // Maps one digit value to its upper-case ASCII character.
  function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [3:0] d);
    logic [CHAR_W-1:0] res;
    if (d < 4'd10) begin
      res = CHAR_ZERO + {4'b0000, d};
    end else begin
      res = CHAR_A + {4'b0000, d - 4'd10};
    end
    return res;
  endfunction

endpackage

// ===== sv/integer_to_ascii_converter_unit.sv =====
// Integer to ASCII converter, top level.
// Depends on itoa_pkg.
//
// The block takes one 64-bit number per input item (tuser bit 0 selects signed
// decimal when 0, unsigned upper-case hexadecimal when 1) and emits its ASCII
// characters most significant first, one output item per character, with '-'
// before a negative decimal value. The final character carries tlast and the
// total character count in tuser; other characters carry a count of zero.
// Decimal conversion runs a bit-serial double dabble, one input bit a cycle,
// over all 64 bits of the number; hexadecimal skips it. Leading zero digits
// are then dropped one digit a cycle, keeping at least one digit, and
// characters leave one a cycle while the output side takes them. One number is
// handled at a time. The next number is accepted in the cycle after the last
// character is loaded into the output register.
module integer_to_ascii_converter_unit
  import itoa_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  logic [NUM_W-1:0]   s_axis_tdata_i,   // [63:0] number
  input  logic [0:0]         s_axis_tuser_i,   // [0] action
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  output logic [CHAR_W-1:0]  m_axis_tdata_o,   // [7:0] character
  output logic               m_axis_tlast_o,
  output logic [COUNT_W-1:0] m_axis_tuser_o    // [4:0] char_count
);

  state_e state_q, state_d;

  logic [NUM_W-1:0]   mag_q, mag_d;
  logic [BCD_W-1:0]   bcd_q, bcd_d;
  logic [BIT_W-1:0]   bit_cnt_q, bit_cnt_d;
  logic [COUNT_W-1:0] dig_cnt_q, dig_cnt_d;
  logic [COUNT_W-1:0] tot_cnt_q, tot_cnt_d;
  logic               neg_q, neg_d;
  logic               sign_pend_q, sign_pend_d;

  logic               out_valid_q, out_valid_d;
  logic [CHAR_W-1:0]  out_char_q, out_char_d;
  logic               out_last_q, out_last_d;
  logic [COUNT_W-1:0] out_count_q, out_count_d;

  logic               in_accept;
  logic               out_load;
  logic               top_zero;
  logic               is_neg;
  logic [BCD_W-1:0]   bcd_adj;
  logic [3:0]         top_digit;

  assign in_accept = s_axis_tvalid_i && s_axis_tready_o;
  assign out_load  = !out_valid_q || m_axis_tready_i;
  assign top_digit = bcd_q[BCD_W-1 -: 4];
  assign top_zero  = (top_digit == 4'd0);
  assign is_neg    = (s_axis_tuser_i[0] == MODE_DEC) && s_axis_tdata_i[NUM_W-1];

  // Double dabble correction: add three to every digit of five or more.
  always_comb begin
    logic [3:0] nib;
    nib     = 4'd0;
    bcd_adj = '0;
    for (int i = 0; i < DIGITS; i++) begin
      nib = bcd_q[i*4 +: 4];
      bcd_adj[i*4 +: 4] = (nib >= 4'd5) ? nib + 4'd3 : nib;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          state_d = (s_axis_tuser_i[0] == MODE_HEX) ? ST_STRIP : ST_CONV;
        end
      end
      ST_CONV: begin
        if (bit_cnt_q == '0) begin
          state_d = ST_STRIP;
        end
      end
      ST_STRIP: begin
        if (!(top_zero && dig_cnt_q > COUNT_W'(1))) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_load && !sign_pend_q && dig_cnt_q == COUNT_W'(1)) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and output register updates.
  always_comb begin
    mag_d       = mag_q;
    bcd_d       = bcd_q;
    bit_cnt_d   = bit_cnt_q;
    dig_cnt_d   = dig_cnt_q;
    tot_cnt_d   = tot_cnt_q;
    neg_d       = neg_q;
    sign_pend_d = sign_pend_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;
    out_count_d = out_count_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          neg_d       = is_neg;
          sign_pend_d = is_neg;
          dig_cnt_d   = COUNT_W'(DIGITS);
          bit_cnt_d   = BIT_W'(NUM_W - 1);
          mag_d       = is_neg ? (NUM_W'(0) - s_axis_tdata_i) : s_axis_tdata_i;
          bcd_d       = (s_axis_tuser_i[0] == MODE_HEX) ? BCD_W'(s_axis_tdata_i) : '0;
        end
      end
      ST_CONV: begin
        bcd_d     = {bcd_adj[BCD_W-2:0], mag_q[NUM_W-1]};
        mag_d     = {mag_q[NUM_W-2:0], 1'b0};
        bit_cnt_d = bit_cnt_q - BIT_W'(1);
      end
      ST_STRIP: begin
        if (top_zero && dig_cnt_q > COUNT_W'(1)) begin
          bcd_d     = {bcd_q[BCD_W-5:0], 4'd0};
          dig_cnt_d = dig_cnt_q - COUNT_W'(1);
        end else begin
          // The string length is the digit count plus the sign.
          tot_cnt_d = dig_cnt_q + COUNT_W'(neg_q);
        end
      end
      ST_EMIT: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          if (sign_pend_q) begin
            sign_pend_d = 1'b0;
            out_char_d  = CHAR_MINUS;
            out_last_d  = 1'b0;
            out_count_d = '0;
          end else begin
            out_char_d  = digit_to_ascii(top_digit);
            out_last_d  = (dig_cnt_q == COUNT_W'(1));
            out_count_d = (dig_cnt_q == COUNT_W'(1)) ? tot_cnt_q : '0;
            bcd_d       = {bcd_q[BCD_W-5:0], 4'd0};
            dig_cnt_d   = dig_cnt_q - COUNT_W'(1);
          end
        end
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    mag_q       <= mag_d;
    bcd_q       <= bcd_d;
    bit_cnt_q   <= bit_cnt_d;
    dig_cnt_q   <= dig_cnt_d;
    tot_cnt_q   <= tot_cnt_d;
    neg_q       <= neg_d;
    sign_pend_q <= sign_pend_d;
    out_char_q  <= out_char_d;
    out_last_q  <= out_last_d;
    out_count_q <= out_count_d;
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_char_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tuser_o  = out_count_q;

endmodule

// ===== sv/itoa_checker.sv =====
// Port-level checker for the integer to ASCII converter, with its bind.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module itoa_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid_i,
  input logic       s_axis_tready_o,
  input logic       m_axis_tvalid_o,
  input logic       m_axis_tready_i,
  input logic [7:0] m_axis_tdata_o,
  input logic       m_axis_tlast_o,
  input logic [4:0] m_axis_tuser_o
);

  // A stalled output item holds its character.
  `ASSERT_NXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o))

  // Characters before the last carry a count of zero.
  `ASSERT_IMP(a_count_zero, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tlast_o, m_axis_tuser_o == 5'd0)

  // The last character carries a count from one to twenty.
  `ASSERT_IMP(a_count_range, clk_i, rst_ni, m_axis_tvalid_o && m_axis_tlast_o, m_axis_tuser_o >= 5'd1 && m_axis_tuser_o <= 5'd20)

  // After a number is accepted the block is busy converting it.
  `ASSERT_NXT(a_busy, clk_i, rst_ni, s_axis_tvalid_i && s_axis_tready_o, !s_axis_tready_o)

endmodule

bind integer_to_ascii_converter_unit itoa_checker u_itoa_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);
